>>> sv/cprg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprg_pkg
// Widths, register indexes, reset values and parameter defaults of the
// camera primary ray generator.
// ----------------------------------------------------------------------------
package cprg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  localparam int SIDE_W   = 13;
  localparam int SIGHT_W  = 24;
  localparam int AXIS_W   = 60;
  localparam int COMP_W   = 20;
  localparam int STRATA_W = 5;

  localparam int PIX_W    = 24;
  localparam int SMP_W    = 8;
  localparam int JIT_W    = 16;
  localparam int DIR_W    = 20;
  localparam int DIR_FRAC = 18;

  localparam int MAX_IMAGE_SIDE_DEF = 4096;
  localparam int MAX_STRATA_DEF     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGHT_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_AXIS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_AXIS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_AXIS        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRATA_SIDE    = 3'd6;

  localparam logic [SIDE_W-1:0]   RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [SIDE_W-1:0]   RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [SIGHT_W-1:0]  RST_SIGHT_DISTANCE = 24'd256;
  localparam logic [STRATA_W-1:0] RST_STRATA_SIDE    = 5'd1;

endpackage

>>> sv/camera_primary_ray_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_primary_ray_generator
// Pinhole camera primary ray generator with stratified jitter.
//
// Input channel: a beat is taken at each rising edge with start high and busy
// low. Each beat carries a linear pixel index, a sample index and two jitter
// fractions. busy is high only during reset, so a beat can enter every cycle.
// Result channel: done marks one cycle in which dir_x, dir_y, dir_z and
// ray_pixel hold one result beat; the receiver cannot stall, and results
// leave in the order the beats came in.
// Configuration: cfg_we writes cfg_data into the register named by cfg_index
// at a rising edge; the user must change registers only while no beat is in
// flight, since the block itself does not enforce this. Throughput is one
// beat per cycle. The pipeline holds the 24-step pixel divider, the 24-step
// jitter divider, the 32-step square root and the 19-step normalizing
// divider, all pipelined one step per stage, plus eleven arithmetic stages
// and the input and output registers.
// Reset restores the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module camera_primary_ray_generator #(
  parameter int MAX_IMAGE_SIDE = cprg_pkg::MAX_IMAGE_SIDE_DEF,
  parameter int MAX_STRATA     = cprg_pkg::MAX_STRATA_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [cprg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cprg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [cprg_pkg::PIX_W-1:0]            pixel_index,
  input  logic [cprg_pkg::SMP_W-1:0]            sample_index,
  input  logic [cprg_pkg::JIT_W-1:0]            jitter_u,
  input  logic [cprg_pkg::JIT_W-1:0]            jitter_v,
  output logic                                  done,
  output logic signed [cprg_pkg::DIR_W-1:0]     dir_x,
  output logic signed [cprg_pkg::DIR_W-1:0]     dir_y,
  output logic signed [cprg_pkg::DIR_W-1:0]     dir_z,
  output logic [cprg_pkg::PIX_W-1:0]            ray_pixel
);

  localparam int PW     = cprg_pkg::PIX_W;
  localparam int JW     = cprg_pkg::JIT_W;
  localparam int QW     = cprg_pkg::SMP_W + cprg_pkg::JIT_W;
  localparam int CW     = cprg_pkg::COMP_W;
  localparam int FR     = cprg_pkg::DIR_FRAC;
  localparam int QB     = FR + 1;
  localparam int WB_RAW = $clog2(MAX_IMAGE_SIDE + 1);
  localparam int WB     = (WB_RAW > cprg_pkg::SIDE_W) ? cprg_pkg::SIDE_W : WB_RAW;
  localparam int SB_RAW = $clog2(MAX_STRATA + 1);
  localparam int SB     = (SB_RAW > cprg_pkg::STRATA_W) ? cprg_pkg::STRATA_W : SB_RAW;
  localparam int UHI    = QW - JW;
  localparam int LAT    = 1 + PW + QW + 11 + 32 + QB + 1;

  typedef struct packed {
    logic [PW-1:0] pix;
    logic [PW-1:0] pnq;
    logic [WB-1:0] prem;
    logic [PW-1:0] snq;
    logic [SB-1:0] srem;
    logic [JW-1:0] ju;
    logic [JW-1:0] jv;
  } div1_t;

  typedef struct packed {
    logic [PW-1:0] pix;
    logic [WB-1:0] col;
    logic [PW-1:0] row;
    logic [QW-1:0] unq;
    logic [SB-1:0] urem;
    logic [QW-1:0] vnq;
    logic [SB-1:0] vrem;
  } div2_t;

  typedef struct packed {
    logic [PW-1:0]       pix;
    logic [63:0]         n;
    logic [63:0]         r;
    logic [2:0]          neg;
    logic                zero;
    logic [2:0][29:0]    mag;
  } root_t;

  typedef struct packed {
    logic [PW-1:0]       pix;
    logic [30:0]         dv;
    logic [2:0]          neg;
    logic                zero;
    logic [2:0][30:0]    rem;
    logic [2:0][QB-1:0]  qnq;
  } div3_t;

  logic [cprg_pkg::SIDE_W-1:0]   image_width;
  logic [cprg_pkg::SIDE_W-1:0]   image_height;
  logic [cprg_pkg::SIGHT_W-1:0]  sight_distance;
  logic [cprg_pkg::AXIS_W-1:0]   front_axis;
  logic [cprg_pkg::AXIS_W-1:0]   right_axis;
  logic [cprg_pkg::AXIS_W-1:0]   up_axis;
  logic [cprg_pkg::STRATA_W-1:0] strata_side;

  logic [WB-1:0] w_eff;
  logic [WB-1:0] h_eff;
  logic [SB-1:0] s_eff;
  logic signed [CW-1:0] f_c [3];
  logic signed [CW-1:0] r_c [3];
  logic signed [CW-1:0] u_c [3];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= cprg_pkg::RST_IMAGE_WIDTH;
      image_height   <= cprg_pkg::RST_IMAGE_HEIGHT;
      sight_distance <= cprg_pkg::RST_SIGHT_DISTANCE;
      front_axis     <= '0;
      right_axis     <= '0;
      up_axis        <= '0;
      strata_side    <= cprg_pkg::RST_STRATA_SIDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cprg_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[cprg_pkg::SIDE_W-1:0];
        cprg_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[cprg_pkg::SIDE_W-1:0];
        cprg_pkg::REG_SIGHT_DISTANCE: sight_distance <= cfg_data[cprg_pkg::SIGHT_W-1:0];
        cprg_pkg::REG_FRONT_AXIS:     front_axis     <= cfg_data[cprg_pkg::AXIS_W-1:0];
        cprg_pkg::REG_RIGHT_AXIS:     right_axis     <= cfg_data[cprg_pkg::AXIS_W-1:0];
        cprg_pkg::REG_UP_AXIS:        up_axis        <= cfg_data[cprg_pkg::AXIS_W-1:0];
        cprg_pkg::REG_STRATA_SIDE:    strata_side    <= cfg_data[cprg_pkg::STRATA_W-1:0];
        default: ;
      endcase
    end
  end

  // A width or strata side of zero is used as one; oversized values are clamped.
  always_comb begin
    if (image_width == '0) w_eff = WB'(1);
    else if (int'(image_width) > MAX_IMAGE_SIDE) w_eff = WB'(MAX_IMAGE_SIDE);
    else w_eff = WB'(image_width);
    if (int'(image_height) > MAX_IMAGE_SIDE) h_eff = WB'(MAX_IMAGE_SIDE);
    else h_eff = WB'(image_height);
    if (strata_side == '0) s_eff = SB'(1);
    else if (int'(strata_side) > MAX_STRATA) s_eff = SB'(MAX_STRATA);
    else s_eff = SB'(strata_side);
    for (int i = 0; i < 3; i++) begin
      f_c[i] = front_axis[CW*i +: CW];
      r_c[i] = right_axis[CW*i +: CW];
      u_c[i] = up_axis[CW*i +: CW];
    end
  end

  // Column, row and stratum cell: one quotient bit per stage.
  div1_t s1 [0:PW];
  logic  v1 [0:PW];

  always_ff @(posedge clk) begin
    if (rst) v1[0] <= 1'b0;
    else v1[0] <= start;
  end

  always_ff @(posedge clk) begin
    s1[0] <= '{pix: pixel_index, pnq: pixel_index, prem: '0,
               snq: PW'(sample_index), srem: '0, ju: jitter_u, jv: jitter_v};
  end

  for (genvar g = 0; g < PW; g++) begin : g_div1
    logic [WB:0] tp;
    logic [SB:0] ts;
    div1_t       nx;
    always_comb begin
      nx = s1[g];
      tp = {s1[g].prem, s1[g].pnq[PW-1]};
      ts = {s1[g].srem, s1[g].snq[PW-1]};
      if (tp >= {1'b0, w_eff}) begin
        nx.prem = WB'(tp - {1'b0, w_eff});
        nx.pnq  = {s1[g].pnq[PW-2:0], 1'b1};
      end else begin
        nx.prem = tp[WB-1:0];
        nx.pnq  = {s1[g].pnq[PW-2:0], 1'b0};
      end
      if (ts >= {1'b0, s_eff}) begin
        nx.srem = SB'(ts - {1'b0, s_eff});
        nx.snq  = {s1[g].snq[PW-2:0], 1'b1};
      end else begin
        nx.srem = ts[SB-1:0];
        nx.snq  = {s1[g].snq[PW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v1[g+1] <= 1'b0;
      else v1[g+1] <= v1[g];
    end
    always_ff @(posedge clk) s1[g+1] <= nx;
  end

  // Jittered offsets inside the pixel: divide by the strata side.
  div2_t s2 [0:QW];
  logic  v2 [0:QW];

  always_comb begin
    v2[0] = v1[PW];
    s2[0] = '{pix: s1[PW].pix, col: s1[PW].prem, row: s1[PW].pnq,
              unq: {UHI'(s1[PW].srem), s1[PW].ju}, urem: '0,
              vnq: {s1[PW].snq[cprg_pkg::SMP_W-1:0], s1[PW].jv}, vrem: '0};
  end

  for (genvar g = 0; g < QW; g++) begin : g_div2
    logic [SB:0] tu;
    logic [SB:0] tv;
    div2_t       nx;
    always_comb begin
      nx = s2[g];
      tu = {s2[g].urem, s2[g].unq[QW-1]};
      tv = {s2[g].vrem, s2[g].vnq[QW-1]};
      if (tu >= {1'b0, s_eff}) begin
        nx.urem = SB'(tu - {1'b0, s_eff});
        nx.unq  = {s2[g].unq[QW-2:0], 1'b1};
      end else begin
        nx.urem = tu[SB-1:0];
        nx.unq  = {s2[g].unq[QW-2:0], 1'b0};
      end
      if (tv >= {1'b0, s_eff}) begin
        nx.vrem = SB'(tv - {1'b0, s_eff});
        nx.vnq  = {s2[g].vnq[QW-2:0], 1'b1};
      end else begin
        nx.vrem = tv[SB-1:0];
        nx.vnq  = {s2[g].vnq[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v2[g+1] <= 1'b0;
      else v2[g+1] <= v2[g];
    end
    always_ff @(posedge clk) s2[g+1] <= nx;
  end

  // Arithmetic stages between the dividers and the square root.
  logic [43:0] x_full;
  logic [43:0] y_full;

  logic                vxy, vmu, va, vd, vm, vx, vl1, vl2, vsh, vsq;
  logic [PW-1:0]       pix_xy, pix_mu, pix_a, pix_d, pix_m, pix_x;
  logic [PW-1:0]       pix_l1, pix_l2, pix_sh, pix_sq;
  logic signed [31:0]  x_xy;
  logic signed [42:0]  y_xy;
  logic signed [32:0]  z_xy;
  logic signed [62:0]  pf [3];
  logic signed [62:0]  pr [3];
  logic signed [62:0]  pu [3];
  logic signed [62:0]  a_s [3];
  logic signed [62:0]  pu_a [3];
  logic signed [62:0]  d_s [3];
  logic [2:0]          neg_m, neg_x, neg_l1, neg_l2, neg_sh, neg_sq;
  logic [61:0]         mag_m [3];
  logic [61:0]         mag_x [3];
  logic [61:0]         mag_l1 [3];
  logic [61:0]         mag_l2 [3];
  logic [61:0]         max_x;
  logic [7:0]          gnz_l1;
  logic [2:0]          gpos_l1 [8];
  logic [5:0]          p_l2;
  logic                zero_l2, zero_sh, zero_sq;
  logic [29:0]         mag_sh [3];
  logic [29:0]         mag_sq [3];
  logic [59:0]         sq_sq [3];

  logic [61:0]         max_n;
  logic [63:0]         m64;
  logic [7:0]          gnz_n;
  logic [2:0]          gpos_n [8];
  logic [5:0]          p_n;
  logic [61:0]         sh_t [3];
  logic [29:0]         mag_shn [3];

  always_comb begin
    x_full = 44'({s2[QW].col, 16'b0}) + 44'(s2[QW].unq) - 44'({w_eff, 15'b0});
    y_full = 44'({h_eff, 15'b0}) - 44'({s2[QW].row, 16'b0}) - 44'(s2[QW].vnq);

    max_n = mag_m[0];
    if (mag_m[1] > max_n) max_n = mag_m[1];
    if (mag_m[2] > max_n) max_n = mag_m[2];

    m64 = {2'b0, max_x};
    for (int j = 0; j < 8; j++) begin
      gnz_n[j]  = |m64[8*j +: 8];
      gpos_n[j] = '0;
      for (int b = 0; b < 8; b++) begin
        if (m64[8*j+b]) gpos_n[j] = 3'(b);
      end
    end

    p_n = '0;
    for (int j = 0; j < 8; j++) begin
      if (gnz_l1[j]) p_n = {3'(j), gpos_l1[j]};
    end

    // Bring the largest magnitude into bit 29 by one common shift.
    for (int i = 0; i < 3; i++) begin
      if (p_l2 >= 6'd29) sh_t[i] = mag_l2[i] >> (p_l2 - 6'd29);
      else sh_t[i] = mag_l2[i] << (6'd29 - p_l2);
      mag_shn[i] = sh_t[i][29:0];
    end
  end

  root_t s3 [0:32];
  logic  v3 [0:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      vxy <= 1'b0; vmu <= 1'b0; va <= 1'b0; vd <= 1'b0; vm <= 1'b0;
      vx <= 1'b0; vl1 <= 1'b0; vl2 <= 1'b0; vsh <= 1'b0; vsq <= 1'b0;
      v3[0] <= 1'b0;
    end else begin
      vxy <= v2[QW]; vmu <= vxy; va <= vmu; vd <= va; vm <= vd;
      vx <= vm; vl1 <= vx; vl2 <= vl1; vsh <= vl2; vsq <= vsh;
      v3[0] <= vsq;
    end
  end

  always_ff @(posedge clk) begin
    pix_xy <= s2[QW].pix;
    x_xy   <= x_full[31:0];
    y_xy   <= y_full[42:0];
    z_xy   <= {1'b0, sight_distance, 8'b0};

    pix_mu <= pix_xy;
    for (int i = 0; i < 3; i++) begin
      pf[i] <= f_c[i] * z_xy;
      pr[i] <= r_c[i] * x_xy;
      pu[i] <= u_c[i] * y_xy;
    end

    pix_a <= pix_mu;
    for (int i = 0; i < 3; i++) begin
      a_s[i]  <= pf[i] + pr[i];
      pu_a[i] <= pu[i];
    end

    pix_d <= pix_a;
    for (int i = 0; i < 3; i++) d_s[i] <= a_s[i] + pu_a[i];

    pix_m <= pix_d;
    for (int i = 0; i < 3; i++) begin
      neg_m[i] <= d_s[i][62];
      mag_m[i] <= d_s[i][62] ? 62'(-d_s[i]) : 62'(d_s[i]);
    end

    pix_x <= pix_m;
    neg_x <= neg_m;
    mag_x <= mag_m;
    max_x <= max_n;

    pix_l1  <= pix_x;
    neg_l1  <= neg_x;
    mag_l1  <= mag_x;
    gnz_l1  <= gnz_n;
    gpos_l1 <= gpos_n;

    pix_l2  <= pix_l1;
    neg_l2  <= neg_l1;
    mag_l2  <= mag_l1;
    p_l2    <= p_n;
    zero_l2 <= ~|gnz_l1;

    pix_sh  <= pix_l2;
    neg_sh  <= neg_l2;
    zero_sh <= zero_l2;
    mag_sh  <= mag_shn;

    pix_sq  <= pix_sh;
    neg_sq  <= neg_sh;
    zero_sq <= zero_sh;
    mag_sq  <= mag_sh;
    for (int i = 0; i < 3; i++) sq_sq[i] <= mag_sh[i] * mag_sh[i];

    s3[0].pix  <= pix_sq;
    s3[0].n    <= 64'(sq_sq[0]) + 64'(sq_sq[1]) + 64'(sq_sq[2]);
    s3[0].r    <= '0;
    s3[0].neg  <= neg_sq;
    s3[0].zero <= zero_sq;
    for (int i = 0; i < 3; i++) s3[0].mag[i] <= mag_sq[i];
  end

  // Integer square root, one result bit per stage.
  for (genvar g = 0; g < 32; g++) begin : g_root
    localparam logic [63:0] BITV = 64'd1 << (2 * (31 - g));
    logic [63:0] trial;
    root_t       nx;
    always_comb begin
      nx    = s3[g];
      trial = s3[g].r + BITV;
      if (s3[g].n >= trial) begin
        nx.n = s3[g].n - trial;
        nx.r = (s3[g].r >> 1) + BITV;
      end else begin
        nx.r = s3[g].r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v3[g+1] <= 1'b0;
      else v3[g+1] <= v3[g];
    end
    always_ff @(posedge clk) s3[g+1] <= nx;
  end

  // Rounded quotients of each magnitude by the norm.
  div3_t       s4 [0:QB];
  logic        v4 [0:QB];
  logic [48:0] num [3];

  always_comb begin
    v4[0]      = v3[32];
    s4[0].pix  = s3[32].pix;
    s4[0].dv   = s3[32].r[30:0];
    s4[0].neg  = s3[32].neg;
    s4[0].zero = s3[32].zero;
    for (int i = 0; i < 3; i++) begin
      num[i] = 49'({s3[32].mag[i], 18'b0}) + 49'(s3[32].r[30:1]);
      s4[0].rem[i] = 31'(num[i][48:QB]);
      s4[0].qnq[i] = num[i][QB-1:0];
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div3
    logic [31:0] tq [3];
    div3_t       nx;
    always_comb begin
      nx = s4[g];
      for (int i = 0; i < 3; i++) begin
        tq[i] = {s4[g].rem[i], s4[g].qnq[i][QB-1]};
        if (tq[i] >= {1'b0, s4[g].dv}) begin
          nx.rem[i] = 31'(tq[i] - {1'b0, s4[g].dv});
          nx.qnq[i] = {s4[g].qnq[i][QB-2:0], 1'b1};
        end else begin
          nx.rem[i] = tq[i][30:0];
          nx.qnq[i] = {s4[g].qnq[i][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v4[g+1] <= 1'b0;
      else v4[g+1] <= v4[g];
    end
    always_ff @(posedge clk) s4[g+1] <= nx;
  end

  logic [cprg_pkg::DIR_W-1:0] qv   [3];
  logic [cprg_pkg::DIR_W-1:0] dirv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = cprg_pkg::DIR_W'(s4[QB].qnq[i]);
      if (s4[QB].zero) dirv[i] = '0;
      else if (s4[QB].neg[i]) dirv[i] = -qv[i];
      else dirv[i] = qv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v4[QB];
  end

  always_ff @(posedge clk) begin
    dir_x     <= dirv[0];
    dir_y     <= dirv[1];
    dir_z     <= dirv[2];
    ray_pixel <= s4[QB].pix;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without an input beat at the pipeline latency");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (dir_x <= 20'sd262144 && dir_x >= -20'sd262144 &&
              dir_y <= 20'sd262144 && dir_y >= -20'sd262144 &&
              dir_z <= 20'sd262144 && dir_z >= -20'sd262144))
    else $error("direction component beyond unit range");

  a_normalized: assert property (@(posedge clk) disable iff (rst)
    (vsh && !zero_sh) |-> (mag_sh[0][29] || mag_sh[1][29] || mag_sh[2][29]))
    else $error("largest magnitude not brought to bit 29");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (v3[32] && !s3[32].zero) |-> (s3[32].r[30:29] != 2'b00 && s3[32].r[63:31] == '0))
    else $error("norm out of expected range");

endmodule
